/* hw/rtl/sgdtu_pkg.sv */
// shared types and constants of the sgd train unit
// word map, command flags, config indexes and controller opcodes
package sgdtu_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;

  localparam logic [AddrW-1:0] AddrGrad = 7'd12;
  localparam logic [AddrW-1:0] AddrCmd  = 7'd28;
  localparam logic [AddrW-1:0] AddrW1   = 7'd32;
  localparam logic [AddrW-1:0] AddrW2   = 7'd48;
  localparam logic [AddrW-1:0] AddrD2   = 7'd64;
  localparam logic [AddrW-1:0] AddrD1   = 7'd68;
  localparam logic [AddrW-1:0] AddrLoss = 7'd76;
  localparam logic [AddrW-1:0] AddrBusy = 7'd77;

  localparam int unsigned FlagLoss = 0;
  localparam int unsigned FlagD1   = 1;
  localparam int unsigned FlagL2   = 2;
  localparam int unsigned FlagL1   = 3;
  localparam int unsigned FlagClr  = 4;
  localparam int unsigned NumFlags = 5;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef enum logic [2:0] {
    CFG_FRAC_BITS   = 3'd0,
    CFG_LEAK_SHIFT  = 3'd1,
    CFG_ERR_CLAMP   = 3'd2,
    CFG_DELTA_CLAMP = 3'd3,
    CFG_LR_SHIFT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ERR,
    OP_MSQ,
    OP_LOSS,
    OP_DOUT,
    OP_HLD,
    OP_MSL,
    OP_DHID,
    OP_UPD2,
    OP_UPD1,
    OP_CLR
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

endpackage

/* hw/rtl/sgdtu_ctrl.sv */
// sequencer of the train unit: walks the flagged steps element by element
// depends on sgdtu_pkg
module sgdtu_ctrl #(
  parameter int unsigned N_OUT = 2,
  parameter int unsigned N_HID = 4,
  parameter int unsigned N_IN  = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [sgdtu_pkg::NumFlags-1:0]      flags_i,
  output sgdtu_pkg::dp_cmd_t                  cmd_o,
  output logic                                idle_o
);
  import sgdtu_pkg::*;

  localparam logic [IdxW-1:0] LastOut = IdxW'(N_OUT - 1);
  localparam logic [IdxW-1:0] LastHid = IdxW'(N_HID - 1);
  localparam logic [IdxW-1:0] LastL2  = IdxW'(N_OUT * N_HID - 1);
  localparam logic [IdxW-1:0] LastL1  = IdxW'(N_HID * N_IN - 1);

  op_e                 state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [NumFlags-1:0] flags_q, flags_d;

  function automatic op_e first_op(input logic [NumFlags-1:0] f);
    op_e r;
    priority if (f[FlagLoss]) r = OP_ERR;
    else if (f[FlagD1])       r = OP_HLD;
    else if (f[FlagL2])       r = OP_UPD2;
    else if (f[FlagL1])       r = OP_UPD1;
    else if (f[FlagClr])      r = OP_CLR;
    else                      r = OP_IDLE;
    return r;
  endfunction

  function automatic logic [NumFlags-1:0] drop(input logic [NumFlags-1:0] f,
                                               input int unsigned b);
    logic [NumFlags-1:0] r;
    r    = f;
    r[b] = 1'b0;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_IDLE;
      idx_q   <= '0;
      flags_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      flags_q <= flags_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    flags_d = flags_q;
    unique case (state_q)
      OP_IDLE: begin
        if (start_i) begin
          flags_d = flags_i;
          idx_d   = '0;
          state_d = first_op(flags_i);
        end
      end
      OP_ERR:  state_d = OP_MSQ;
      OP_MSQ:  state_d = OP_LOSS;
      OP_LOSS: state_d = OP_DOUT;
      OP_DOUT: begin
        if (idx_q == LastOut) begin
          flags_d = drop(flags_q, FlagLoss);
          idx_d   = '0;
          state_d = first_op(flags_d);
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = OP_ERR;
        end
      end
      OP_HLD:  state_d = OP_MSL;
      OP_MSL:  state_d = OP_DHID;
      OP_DHID: begin
        if (idx_q == LastHid) begin
          flags_d = drop(flags_q, FlagD1);
          idx_d   = '0;
          state_d = first_op(flags_d);
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = OP_HLD;
        end
      end
      OP_UPD2: begin
        if (idx_q == LastL2) begin
          flags_d = drop(flags_q, FlagL2);
          idx_d   = '0;
          state_d = first_op(flags_d);
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      OP_UPD1: begin
        if (idx_q == LastL1) begin
          flags_d = drop(flags_q, FlagL1);
          idx_d   = '0;
          state_d = first_op(flags_d);
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      OP_CLR: begin
        flags_d = '0;
        idx_d   = '0;
        state_d = OP_IDLE;
      end
      default: state_d = OP_IDLE;
    endcase
  end

  assign cmd_o.op  = state_q;
  assign cmd_o.idx = idx_q;
  assign idle_o    = (state_q == OP_IDLE);

endmodule

/* hw/rtl/sgdtu_datapath.sv */
// register banks, config, shared multiplier and update logic of the train unit
// depends on sgdtu_pkg; driven by sgdtu_ctrl opcodes
module sgdtu_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [30:0]                   cfg_data_i,
  input  logic                          bus_acc_i,
  input  logic                          bus_cmd_i,
  input  logic [sgdtu_pkg::AddrW-1:0]   bus_addr_i,
  input  logic [sgdtu_pkg::DataW-1:0]   bus_wdata_i,
  input  sgdtu_pkg::dp_cmd_t            cmd_i,
  output logic [sgdtu_pkg::DataW-1:0]   rdata_o
);
  import sgdtu_pkg::*;

  logic [4:0]  frac_q;
  logic [3:0]  leak_q;
  logic [30:0] errc_q, dltc_q;
  logic [4:0]  lr_q;

  logic [DataW-1:0] act_q    [4];
  logic [DataW-1:0] preact_q [4];
  logic [DataW-1:0] target_q [4];
  logic [DataW-1:0] grad_q   [16];
  logic [DataW-1:0] w1_q     [16];
  logic [DataW-1:0] w2_q     [8];
  logic [DataW-1:0] d2_q     [2];
  logic [DataW-1:0] d1_q     [4];
  logic [DataW-1:0] loss_q;
  logic [DataW-1:0] rdata_q;

  logic signed [31:0] e_q;
  logic [16:0]        slope_q;
  logic signed [63:0] prod_q;

  logic [4:0]         feff;
  logic [16:0]        one;
  logic [1:0]         i2;
  logic [2:0]         i3;
  logic signed [32:0] diff;
  logic signed [31:0] e_clamped;
  logic [16:0]        slope_now;
  logic signed [31:0] mul_b;
  logic signed [63:0] rnd_full;
  logic signed [31:0] rnd;
  logic signed [31:0] dlt_clamped;
  logic signed [31:0] upd_w, upd_g;
  logic signed [31:0] upd_res;
  logic signed [32:0] upd_d;
  logic               w_en;
  logic [AddrW-1:0]   grad_off;

  function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] x,
                                                   input logic [30:0] lim);
    logic signed [33:0] l;
    logic signed [31:0] r;
    l = (lim == '0) ? 34'sd1 : $signed({3'b000, lim});
    if ($signed({x[32], x}) < -l)                r = 32'(-l);
    else if ($signed({x[32], x}) > (l - 34'sd1)) r = 32'(l - 34'sd1);
    else                                         r = x[31:0];
    return r;
  endfunction

  assign feff = (frac_q == 5'd0) ? 5'd1 : (frac_q > 5'd16) ? 5'd16 : frac_q;
  assign one  = 17'd1 << feff;
  assign i2   = cmd_i.idx[1:0];
  assign i3   = cmd_i.idx[2:0];

  assign diff      = $signed({act_q[i2][31], act_q[i2]})
                   - $signed({target_q[i2][31], target_q[i2]});
  assign e_clamped = clamp_sym(diff, errc_q);
  assign slope_now = preact_q[i2][31] ? (one >> leak_q) : one;

  assign mul_b    = (cmd_i.op == OP_MSQ) ? e_q : $signed({15'd0, slope_q});
  assign rnd_full = (prod_q + (64'sd1 <<< (feff - 5'd1))) >>> feff;
  assign rnd      = rnd_full[31:0];
  assign dlt_clamped = clamp_sym({rnd[31], rnd}, dltc_q);

  assign upd_w   = (cmd_i.op == OP_UPD2) ? $signed(w2_q[i3]) : $signed(w1_q[cmd_i.idx]);
  assign upd_g   = $signed(grad_q[cmd_i.idx]) >>> lr_q;
  assign upd_d   = $signed({upd_w[31], upd_w}) - $signed({upd_g[31], upd_g});
  assign upd_res = (upd_d < -33'sd32768) ? -32'sd32768 :
                   (upd_d > 33'sd32767)  ?  32'sd32767 : upd_d[31:0];

  assign w_en     = bus_acc_i && (bus_cmd_i == CmdWrite);
  assign grad_off = bus_addr_i - AddrGrad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= 5'd8;
      leak_q <= 4'd3;
      errc_q <= 31'd32768;
      dltc_q <= 31'd32768;
      lr_q   <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAC_BITS:   frac_q <= cfg_data_i[4:0];
        CFG_LEAK_SHIFT:  leak_q <= cfg_data_i[3:0];
        CFG_ERR_CLAMP:   errc_q <= cfg_data_i;
        CFG_DELTA_CLAMP: dltc_q <= cfg_data_i;
        CFG_LR_SHIFT:    lr_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // bus-written banks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        act_q[k]    <= '0;
        preact_q[k] <= '0;
        target_q[k] <= '0;
      end
      for (int k = 0; k < 16; k++) grad_q[k] <= '0;
    end else if (w_en) begin
      if (bus_addr_i < 7'd4)          act_q[bus_addr_i[1:0]]    <= bus_wdata_i;
      else if (bus_addr_i < 7'd8)     preact_q[bus_addr_i[1:0]] <= bus_wdata_i;
      else if (bus_addr_i < AddrGrad) target_q[bus_addr_i[1:0]] <= bus_wdata_i;
      else if (bus_addr_i < AddrCmd)  grad_q[grad_off[3:0]]     <= bus_wdata_i;
    end
  end

  // weights, deltas and loss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) w1_q[k] <= '0;
      for (int k = 0; k < 8; k++)  w2_q[k] <= '0;
      for (int k = 0; k < 2; k++)  d2_q[k] <= '0;
      for (int k = 0; k < 4; k++)  d1_q[k] <= '0;
      loss_q <= '0;
    end else begin
      if (w_en && bus_addr_i >= AddrW1 && bus_addr_i < AddrW2) begin
        w1_q[bus_addr_i[3:0]] <= bus_wdata_i;
      end
      if (w_en && bus_addr_i >= AddrW2 && bus_addr_i < AddrW2 + 7'd8) begin
        w2_q[bus_addr_i[2:0]] <= bus_wdata_i;
      end
      unique case (cmd_i.op)
        OP_LOSS: loss_q <= loss_q + rnd;
        OP_DOUT: d2_q[cmd_i.idx[0]] <= dlt_clamped;
        OP_DHID: d1_q[i2] <= dlt_clamped;
        OP_UPD2: w2_q[i3] <= upd_res;
        OP_UPD1: w1_q[cmd_i.idx] <= upd_res;
        OP_CLR:  loss_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ERR: begin
        e_q     <= e_clamped;
        slope_q <= slope_now;
      end
      OP_HLD: begin
        e_q     <= $signed(act_q[i2]);
        slope_q <= slope_now;
      end
      OP_MSQ, OP_LOSS, OP_MSL: prod_q <= e_q * mul_b;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bus_acc_i && bus_cmd_i == CmdRead) begin
      if (bus_addr_i >= AddrW1 && bus_addr_i < AddrW2)
        rdata_q <= w1_q[bus_addr_i[3:0]];
      else if (bus_addr_i >= AddrW2 && bus_addr_i < AddrW2 + 7'd8)
        rdata_q <= w2_q[bus_addr_i[2:0]];
      else if (bus_addr_i >= AddrD2 && bus_addr_i < AddrD2 + 7'd2)
        rdata_q <= d2_q[bus_addr_i[0]];
      else if (bus_addr_i >= AddrD1 && bus_addr_i < AddrD1 + 7'd4)
        rdata_q <= d1_q[bus_addr_i[1:0]];
      else if (bus_addr_i == AddrLoss)
        rdata_q <= loss_q;
      else
        rdata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sgd_train_unit_registers_core.sv */
// top level of the sgd train unit: stream ports, output register, assertions
// depends on sgdtu_pkg, sgdtu_ctrl, sgdtu_datapath
//
// channel | direction | payload
// s_axis  | in        | tdata[0] cmd, [7:1] word_addr, [39:8] write_data
// m_axis  | out       | tdata[31:0] read_data
// cfg     | in        | index 0..4, data 31 bits
//
// a read or plain write is done as taken; the result sits in an output register
// a command write holds the input through err, msq, loss, dout per output delta,
// hld, msl, dhid per hidden delta, upd per weight and clr for loss clear, set
// by the one multiplier; reset clears control and all banks at once; no input
// while the output register is full and not drained, no config during a command
module sgd_train_unit_registers_core #(
  parameter int unsigned N_OUT = 2,
  parameter int unsigned N_HID = 4,
  parameter int unsigned N_IN  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // cmd, word_addr, write_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // read_data
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  import sgdtu_pkg::*;

  dp_cmd_t          dp_cmd;
  logic             idle;
  logic             acc;
  logic             start;
  logic             out_valid_q;
  logic             bus_cmd;
  logic [AddrW-1:0] bus_addr;
  logic [DataW-1:0] bus_wdata;

  assign bus_cmd   = s_axis_tdata_i[0];
  assign bus_addr  = s_axis_tdata_i[7:1];
  assign bus_wdata = s_axis_tdata_i[39:8];

  assign s_axis_tready_o = idle && (!out_valid_q || m_axis_tready_i);
  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign start = acc && (bus_cmd == CmdWrite) && (bus_addr == AddrCmd);
  assign cfg_ready_o = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && bus_cmd == CmdRead) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  sgdtu_ctrl #(
    .N_OUT(N_OUT),
    .N_HID(N_HID),
    .N_IN (N_IN)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .flags_i(bus_wdata[NumFlags-1:0]),
    .cmd_o  (dp_cmd),
    .idle_o (idle)
  );

  sgdtu_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .bus_acc_i  (acc),
    .bus_cmd_i  (bus_cmd),
    .bus_addr_i (bus_addr),
    .bus_wdata_i(bus_wdata),
    .cmd_i      (dp_cmd),
    .rdata_o    (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> dp_cmd.op == OP_IDLE)
    else $error("input ready while sequencer busy");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && bus_cmd == CmdRead) |=> m_axis_tvalid_o)
    else $error("read transfer without result");

  a_cmd_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && bus_wdata[NumFlags-1:0] != '0) |=> !s_axis_tready_o)
    else $error("command did not start sequencer");
`endif

endmodule

/* tb/sv/sgd_train_unit_registers_core_tb.sv */
// self-checking testbench of the sgd train unit register core
// predicts read data from bus transfers and compares it on the output stream
// depends on sgdtu_pkg and sgd_train_unit_registers_core
`timescale 1ns / 1ps

class read_scoreboard;
  logic [31:0] pending_reads[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_read(logic [31:0] value);
    pending_reads.push_back(value);
  endfunction

  function void check_read(logic [31:0] actual);
    logic [31:0] want;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected read data, expected none, actual %h", $time, actual);
      errors++;
      return;
    end
    want = pending_reads.pop_front();
    if (want !== actual) begin
      $display("%0t: read_data mismatch, expected %h, actual %h", $time, want, actual);
      errors++;
    end
  endfunction
endclass

module sgd_train_unit_registers_core_tb;
  import sgdtu_pkg::*;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  read_scoreboard board;
  int send_idle_pct, recv_idle_pct, stall_cycles;

  logic [4:0] m_frac, m_lr;
  logic [3:0] m_leak;
  logic [30:0] m_errc, m_deltac;
  logic [31:0] m_act[4], m_pre[4], m_tgt[4], m_grad[16];
  logic [31:0] m_w1[16], m_w2[8], m_d2[2], m_d1[4], m_loss;

  sgd_train_unit_registers_core uut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_read(m_axis_tdata_o);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int unsigned frac_used();
    if (m_frac < 1) return 1;
    if (m_frac > 16) return 16;
    return m_frac;
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    int unsigned f;
    logic signed [63:0] p;
    f = frac_used();
    p = (a * b + (64'sd1 <<< (f - 1))) >>> f;
    return p[31:0];
  endfunction

  function automatic logic signed [63:0] clamp_to(logic signed [63:0] x, logic [30:0] lim);
    logic signed [63:0] l;
    l = (lim == 0) ? 64'sd1 : $signed({33'd0, lim});
    if (x < -l) return -l;
    if (x > l - 1) return l - 1;
    return x;
  endfunction

  function automatic logic signed [31:0] leaky_delta(logic signed [63:0] x, logic [31:0] z);
    logic signed [63:0] one, slope;
    one = 64'sd1 <<< frac_used();
    slope = $signed(z) >= 0 ? one : (one >>> m_leak);
    return 32'(clamp_to(fx_mul(x, slope), m_deltac));
  endfunction

  function automatic logic [31:0] step_weight(logic [31:0] w, logic [31:0] g);
    logic signed [63:0] d;
    d = 64'($signed(w)) - (64'($signed(g)) >>> m_lr);
    if (d < -32768) d = -32768;
    if (d > 32767) d = 32767;
    return d[31:0];
  endfunction

  task automatic run_training_cmd(logic [31:0] c);
    logic signed [63:0] e;
    if (c[FlagLoss]) begin
      for (int i = 0; i < 2; i++) begin
        e = clamp_to(64'($signed(m_act[i])) - 64'($signed(m_tgt[i])), m_errc);
        m_loss = m_loss + fx_mul(e, e);
        m_d2[i] = leaky_delta(e, m_pre[i]);
      end
    end
    if (c[FlagD1])
      for (int i = 0; i < 4; i++) m_d1[i] = leaky_delta(64'($signed(m_act[i])), m_pre[i]);
    if (c[FlagL2]) for (int i = 0; i < 8; i++) m_w2[i] = step_weight(m_w2[i], m_grad[i]);
    if (c[FlagL1]) for (int i = 0; i < 16; i++) m_w1[i] = step_weight(m_w1[i], m_grad[i]);
    if (c[FlagClr]) m_loss = '0;
  endtask

  task automatic predict_access(logic cmd, logic [6:0] a, logic [31:0] v);
    logic [31:0] r;
    logic [6:0] off;
    r = '0;
    if (cmd == CmdWrite) begin
      if (a < 4) m_act[a[1:0]] = v;
      else if (a < 8) m_pre[a[1:0]] = v;
      else if (a < AddrGrad) m_tgt[a[1:0]] = v;
      else if (a < AddrCmd) begin off = a - AddrGrad; m_grad[off[3:0]] = v; end
      else if (a == AddrCmd) run_training_cmd(v);
      else if (a >= AddrW1 && a < AddrW1 + 7'd16) begin off = a - AddrW1; m_w1[off[3:0]] = v; end
      else if (a >= AddrW2 && a < AddrW2 + 7'd8) begin off = a - AddrW2; m_w2[off[2:0]] = v; end
      return;
    end
    if (a >= AddrW1 && a < AddrW1 + 7'd16) begin off = a - AddrW1; r = m_w1[off[3:0]]; end
    else if (a >= AddrW2 && a < AddrW2 + 7'd8) begin off = a - AddrW2; r = m_w2[off[2:0]]; end
    else if (a >= AddrD2 && a < AddrD2 + 7'd2) begin off = a - AddrD2; r = m_d2[off[0]]; end
    else if (a >= AddrD1 && a < AddrD1 + 7'd4) begin off = a - AddrD1; r = m_d1[off[1:0]]; end
    else if (a == AddrLoss) r = m_loss;
    board.note_read(r);
  endtask

  task automatic bus_access(logic cmd, logic [6:0] a, logic [31:0] v);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {v, a, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_access(cmd, a, v);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending_reads.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [30:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FRAC_BITS: m_frac = val[4:0];
      CFG_LEAK_SHIFT: m_leak = val[3:0];
      CFG_ERR_CLAMP: m_errc = val;
      CFG_DELTA_CLAMP: m_deltac = val;
      CFG_LR_SHIFT: m_lr = val[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(2047) - 1024;
      3: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) bus_access(CmdWrite, 7'($urandom_range(27)), rand_data());
      else if (kind < 50) bus_access(CmdWrite, AddrCmd, $urandom);
      else if (kind < 60) bus_access(CmdWrite, AddrW1 + 7'($urandom_range(23)), rand_data());
      else if (kind < 90)
        bus_access(CmdRead, (kind < 80) ? AddrW1 + 7'($urandom_range(45))
                                        : 7'($urandom_range(127)),
                   $urandom);
      else bus_access(CmdWrite, 7'($urandom_range(127)), $urandom);
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 21;
    recv_idle_pct = 76;
    stall_cycles = 0;
    m_frac = 8; m_leak = 3; m_errc = 32768; m_deltac = 32768; m_lr = 4; m_loss = '0;
    foreach (m_act[i]) begin m_act[i] = '0; m_pre[i] = '0; m_tgt[i] = '0; m_d1[i] = '0; end
    foreach (m_grad[i]) begin m_grad[i] = '0; m_w1[i] = '0; end
    foreach (m_w2[i]) m_w2[i] = '0;
    foreach (m_d2[i]) m_d2[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset reads, extremes, every flag, unmapped and busy words
    bus_access(CmdRead, AddrBusy, '0);
    bus_access(CmdRead, AddrLoss, '1);
    bus_access(CmdWrite, 7'd0, 32'h7fff_ffff);
    bus_access(CmdWrite, 7'd1, 32'h8000_0000);
    bus_access(CmdWrite, 7'd8, 32'h8000_0000);
    bus_access(CmdWrite, 7'd9, 32'h7fff_ffff);
    bus_access(CmdWrite, 7'd5, 32'h8000_0000);
    bus_access(CmdWrite, AddrCmd, 32'hffff_ffe1);
    bus_access(CmdRead, AddrD2, '0);
    bus_access(CmdRead, AddrD2 + 7'd1, '0);
    bus_access(CmdRead, AddrLoss, '0);
    bus_access(CmdWrite, AddrGrad, 32'h8000_0000);
    bus_access(CmdWrite, AddrGrad + 7'd15, 32'h7fff_ffff);
    bus_access(CmdWrite, AddrCmd, 32'h0000_000e);
    bus_access(CmdRead, AddrD1 + 7'd1, '0);
    bus_access(CmdRead, AddrW2, '0);
    bus_access(CmdRead, AddrW1 + 7'd15, '0);
    bus_access(CmdWrite, AddrCmd, 32'h0000_0010);
    bus_access(CmdRead, AddrLoss, '0);
    bus_access(CmdWrite, 7'd127, 32'hdead_beef);
    bus_access(CmdRead, 7'd127, '0);
    bus_access(CmdRead, 7'd29, '0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) begin send_idle_pct = 76; recv_idle_pct = 21; end
      if (ph == 5) begin send_idle_pct = 0; recv_idle_pct = 0; end
      case (ph)
        0: begin write_cfg(CFG_FRAC_BITS, 31'd1); write_cfg(CFG_LEAK_SHIFT, 31'd0);
           write_cfg(CFG_ERR_CLAMP, 31'd1); write_cfg(CFG_DELTA_CLAMP, 31'd1);
           write_cfg(CFG_LR_SHIFT, 31'd0); end
        1: begin write_cfg(CFG_FRAC_BITS, 31'd16); write_cfg(CFG_LEAK_SHIFT, 31'd15);
           write_cfg(CFG_ERR_CLAMP, 31'h4000_0000); write_cfg(CFG_DELTA_CLAMP, 31'h4000_0000);
           write_cfg(CFG_LR_SHIFT, 31'd31); end
        2: begin write_cfg(CFG_FRAC_BITS, 31'd0); write_cfg(CFG_ERR_CLAMP, 31'd0);
           write_cfg(CFG_DELTA_CLAMP, 31'h7fff_ffff); end
        3: begin write_cfg(CFG_FRAC_BITS, 31'd31); write_cfg(CFG_LEAK_SHIFT, 31'd7); end
        default: begin write_cfg(CFG_FRAC_BITS, 31'($urandom_range(1, 16)));
           write_cfg(CFG_LEAK_SHIFT, 31'($urandom_range(15)));
           write_cfg(CFG_ERR_CLAMP, 31'($urandom_range(1, 65536)));
           write_cfg(CFG_DELTA_CLAMP, 31'($urandom_range(1, 65536)));
           write_cfg(CFG_LR_SHIFT, 31'($urandom_range(8))); end
      endcase
      random_phase(72);
      drain_results();
    end

    if (board.errors == 0 && board.pending_reads.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/sgdtu_pkg.sv
hw/rtl/sgdtu_ctrl.sv
hw/rtl/sgdtu_datapath.sv
hw/rtl/sgd_train_unit_registers_core.sv
tb/sv/sgd_train_unit_registers_core_tb.sv
